>>> sv/stc_pkg.sv
`timescale 1ns / 1ps

package stc_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int LINE_BITS   = 20;
   localparam int COLUMN_BITS = 16;

   localparam int KIND_BITS   = 4;
   localparam int START_BITS  = 24;
   localparam int LENGTH_BITS = 16;
   localparam int TLINE_BITS  = 20;
   localparam int TCOL_BITS   = 16;

   localparam int CHAR_BITS     = 8;
   localparam int RSP_USED_BITS = START_BITS + LENGTH_BITS + TLINE_BITS + TCOL_BITS;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RSP_USED_BITS;

   localparam logic [KIND_BITS-1:0] KIND_END       = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_IDENT     = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER    = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_STRING    = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_PLUS      = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_MINUS     = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_EQUALS    = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_SEMICOLON = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN    = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN    = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_ERROR     = 4'd10;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [START_BITS-1:0]  start;
      logic [LENGTH_BITS-1:0] length;
      logic [TLINE_BITS-1:0]  line;
      logic [TCOL_BITS-1:0]   column;
   } lexeme_type;

   typedef struct packed {
      logic [2:0]            valid;
      lexeme_type [2:0]      tok;
   } bundle_type;

endpackage

>>> sv/stc_scan.sv
`timescale 1ns / 1ps

module stc_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [stc_pkg::CHAR_BITS-1:0] char_code,
   input  logic                          end_of_source,
   output stc_pkg::bundle_type           bundle
);
   import stc_pkg::*;

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_IDENT  = 3'd1;
   localparam logic [2:0] MODE_INT    = 3'd2;
   localparam logic [2:0] MODE_DOT    = 3'd3;
   localparam logic [2:0] MODE_FRAC   = 3'd4;
   localparam logic [2:0] MODE_STRING = 3'd5;

   localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_EQ    = 8'h3D;
   localparam logic [CHAR_BITS-1:0] CH_SEMI  = 8'h3B;
   localparam logic [CHAR_BITS-1:0] CH_LPAR  = 8'h28;
   localparam logic [CHAR_BITS-1:0] CH_RPAR  = 8'h29;
   localparam logic [CHAR_BITS-1:0] CH_QUOTE = 8'h22;
   localparam logic [CHAR_BITS-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_BITS-1:0] CH_UNDER = 8'h5F;

   function automatic logic ident_head(input logic [CHAR_BITS-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
   endfunction

   function automatic logic decimal_digit(input logic [CHAR_BITS-1:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   logic [2:0]             mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [OFFSET_BITS-1:0] begin_ff, begin_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic [COLUMN_BITS-1:0] bcol_ff, bcol_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;

   logic [LENGTH_BITS-1:0] len_inc;
   logic [LENGTH_BITS:0]   len_add2;
   logic [LENGTH_BITS-1:0] len_inc2;
   logic [OFFSET_BITS-1:0] offset_adv;
   logic [LINE_BITS-1:0]   line_adv;
   logic [COLUMN_BITS-1:0] column_adv;

   logic                   st_ws;
   logic                   st_emit;
   logic [KIND_BITS-1:0]   st_kind;
   logic [2:0]             st_mode;

   logic                   do_start;
   logic                   p_valid;
   logic [KIND_BITS-1:0]   p_kind;
   logic [LENGTH_BITS-1:0] p_len;
   logic                   d_valid;
   logic                   s_valid;
   lexeme_type             p_tok;
   lexeme_type             d_tok;
   lexeme_type             s_tok;

   assign len_inc    = (&len_ff) ? len_ff : len_ff + 1'b1;
   assign len_add2   = {1'b0, len_ff} + (LENGTH_BITS + 1)'(2);
   assign len_inc2   = len_add2[LENGTH_BITS] ? '1 : len_add2[LENGTH_BITS-1:0];
   assign offset_adv = (&offset_ff) ? offset_ff : offset_ff + 1'b1;

   always_comb begin
      if (char_code == CH_LF) begin
         line_adv   = (&line_ff) ? line_ff : line_ff + 1'b1;
         column_adv = COLUMN_BITS'(1);
      end else begin
         line_adv   = line_ff;
         column_adv = (&column_ff) ? column_ff : column_ff + 1'b1;
      end
   end

   always_comb begin
      st_ws   = 1'b0;
      st_emit = 1'b1;
      st_kind = KIND_ERROR;
      st_mode = MODE_IDLE;
      unique case (char_code) inside
         CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
            st_ws   = 1'b1;
            st_emit = 1'b0;
         end
         CH_PLUS:  st_kind = KIND_PLUS;
         CH_MINUS: st_kind = KIND_MINUS;
         CH_EQ:    st_kind = KIND_EQUALS;
         CH_SEMI:  st_kind = KIND_SEMICOLON;
         CH_LPAR:  st_kind = KIND_LPAREN;
         CH_RPAR:  st_kind = KIND_RPAREN;
         CH_QUOTE: begin
            st_emit = 1'b0;
            st_mode = MODE_STRING;
         end
         default: begin
            if (ident_head(char_code)) begin
               st_emit = 1'b0;
               st_mode = MODE_IDENT;
            end else if (decimal_digit(char_code)) begin
               st_emit = 1'b0;
               st_mode = MODE_INT;
            end
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      offset_in = offset_ff;
      begin_in  = begin_ff;
      line_in   = line_ff;
      column_in = column_ff;
      bcol_in   = bcol_ff;
      len_in    = len_ff;
      do_start  = 1'b0;
      p_valid   = 1'b0;
      p_kind    = KIND_ERROR;
      p_len     = len_ff;
      d_valid   = 1'b0;
      s_valid   = 1'b0;
      s_tok.kind   = st_kind;
      s_tok.start  = START_BITS'(offset_ff);
      s_tok.length = LENGTH_BITS'(1);
      s_tok.line   = TLINE_BITS'(line_ff);
      s_tok.column = TCOL_BITS'(column_ff);
      if (fire) begin
         if (end_of_source) begin
            mode_in = MODE_IDLE;
            unique case (mode_ff) inside
               MODE_IDENT: begin
                  p_valid = 1'b1;
                  p_kind  = KIND_IDENT;
               end
               MODE_INT, MODE_FRAC: begin
                  p_valid = 1'b1;
                  p_kind  = KIND_NUMBER;
               end
               MODE_DOT: begin
                  p_valid = 1'b1;
                  p_kind  = KIND_NUMBER;
                  d_valid = 1'b1;
               end
               MODE_STRING: begin
                  p_valid = 1'b1;
                  p_kind  = KIND_ERROR;
               end
               default: ;
            endcase
            s_valid      = 1'b1;
            s_tok.kind   = KIND_END;
            s_tok.length = '0;
         end else begin
            offset_in = offset_adv;
            line_in   = line_adv;
            column_in = column_adv;
            unique case (mode_ff)
               MODE_IDENT: begin
                  if (ident_head(char_code) || decimal_digit(char_code)) begin
                     len_in = len_inc;
                  end else begin
                     p_valid  = 1'b1;
                     p_kind   = KIND_IDENT;
                     do_start = 1'b1;
                  end
               end
               MODE_INT: begin
                  if (decimal_digit(char_code)) begin
                     len_in = len_inc;
                  end else if (char_code == CH_DOT) begin
                     mode_in = MODE_DOT;
                  end else begin
                     p_valid  = 1'b1;
                     p_kind   = KIND_NUMBER;
                     do_start = 1'b1;
                  end
               end
               MODE_DOT: begin
                  if (decimal_digit(char_code)) begin
                     len_in  = len_inc2;
                     mode_in = MODE_FRAC;
                  end else begin
                     p_valid  = 1'b1;
                     p_kind   = KIND_NUMBER;
                     d_valid  = 1'b1;
                     do_start = 1'b1;
                  end
               end
               MODE_FRAC: begin
                  if (decimal_digit(char_code)) begin
                     len_in = len_inc;
                  end else begin
                     p_valid  = 1'b1;
                     p_kind   = KIND_NUMBER;
                     do_start = 1'b1;
                  end
               end
               MODE_STRING: begin
                  if (char_code == CH_QUOTE) begin
                     len_in  = len_inc;
                     p_valid = 1'b1;
                     p_kind  = KIND_STRING;
                     p_len   = len_inc;
                     mode_in = MODE_IDLE;
                  end else if (char_code == CH_LF) begin
                     p_valid  = 1'b1;
                     p_kind   = KIND_ERROR;
                     do_start = 1'b1;
                  end else begin
                     len_in = len_inc;
                  end
               end
               default: do_start = 1'b1;
            endcase
            if (do_start) begin
               mode_in = st_mode;
               s_valid = st_emit;
               if (!st_ws) begin
                  begin_in = offset_ff;
                  bcol_in  = column_ff;
                  len_in   = LENGTH_BITS'(1);
               end
            end
         end
      end
   end

   always_comb begin
      p_tok.kind   = p_kind;
      p_tok.start  = START_BITS'(begin_ff);
      p_tok.length = p_len;
      p_tok.line   = TLINE_BITS'(line_ff);
      p_tok.column = TCOL_BITS'(bcol_ff);
      d_tok.kind   = KIND_ERROR;
      d_tok.start  = START_BITS'(offset_ff - 1'b1);
      d_tok.length = LENGTH_BITS'(1);
      d_tok.line   = TLINE_BITS'(line_ff);
      d_tok.column = TCOL_BITS'(column_ff - 1'b1);
   end

   assign bundle.valid = {s_valid, d_valid, p_valid};
   assign bundle.tok   = {s_tok, d_tok, p_tok};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         offset_ff <= '0;
         begin_ff  <= '0;
         line_ff   <= LINE_BITS'(1);
         column_ff <= COLUMN_BITS'(1);
         bcol_ff   <= COLUMN_BITS'(1);
         len_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
         begin_ff  <= begin_in;
         line_ff   <= line_in;
         column_ff <= column_in;
         bcol_ff   <= bcol_in;
         len_ff    <= len_in;
      end
   end

`ifndef SYNTHESIS
   a_eos_idle: assert property (@(posedge clock) disable iff (reset)
      fire && end_of_source |=> mode_ff == MODE_IDLE)
      else $error("Scan mode is not idle after end of source.");

   a_dot_offset: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DOT |-> offset_ff != '0)
      else $error("Pending dot with a zero byte offset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !fire && !reset |=> $stable(offset_ff) && $stable(mode_ff) && $stable(len_ff))
      else $error("Scanner state moved without a beat.");
`endif

endmodule

>>> sv/stc_emit.sv
`timescale 1ns / 1ps

module stc_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  stc_pkg::bundle_type bundle,
   input  logic                out_ready,
   output logic                out_valid,
   output stc_pkg::lexeme_type out_token,
   output logic                out_last,
   output logic                free
);
   import stc_pkg::*;

   logic [2:0]       mask_ff, mask_in;
   lexeme_type [2:0] tok_ff;
   logic [2:0]       mask_rest;

   assign mask_rest = mask_ff & (mask_ff - 3'd1);
   assign out_valid = mask_ff != '0;
   assign out_last  = out_valid && (mask_rest == '0);
   assign free      = !out_valid || (out_ready && out_last);

   always_comb begin
      if (mask_ff[0]) begin
         out_token = tok_ff[0];
      end else if (mask_ff[1]) begin
         out_token = tok_ff[1];
      end else begin
         out_token = tok_ff[2];
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = bundle.valid;
      end else if (out_valid && out_ready) begin
         mask_in = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff <= bundle.tok;
      end
   end

`ifndef SYNTHESIS
   a_drain: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready && !out_last && !load |=> out_valid)
      else $error("Tokens of a run were dropped.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("Result register loaded while tokens still wait.");
`endif

endmodule

>>> sv/source_char_tokenizer_top.sv
`timescale 1ns / 1ps

// Source text tokenizer. The request channel takes one source byte per beat
// in req_tdata, with req_tlast marking end of source (the byte is then
// ignored). The response channel gives one token per beat: its kind in
// rsp_tuser, its position fields in rsp_tdata, and rsp_tlast on the final
// token caused by one request beat. A byte may cause no token, or up to
// three when a pending dot after a number is settled by end of source or by
// a byte that is not a digit.
// A beat is held in an input register, scanned, and its tokens land in a result
// register; the first token is presented once the beat has passed through both
// registers. One byte is taken every cycle as long as each byte gives at most one
// token and the receiver is ready; a byte that gives two or three tokens holds the
// next byte in the input register while the result register drains.
// If the receiver stalls, the result register and then the input register
// hold their contents and req_tready falls; nothing is dropped.
// Reset restarts the scan between tokens with offset zero, line one and
// column one, and empties both registers.

module source_char_tokenizer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // char_code [7:0]
   input  logic [stc_pkg::CHAR_BITS-1:0]     req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // token_start [23:0], token_length [39:24], token_line [59:40],
   // token_column [75:60], zero fill above
   output logic [stc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // token_kind [3:0]
   output logic [stc_pkg::KIND_BITS-1:0]     rsp_tuser,
   output logic                              rsp_tlast
);
   import stc_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0] char_ff;
   logic                 eos_ff;
   logic                 bundle_free;
   logic                 scan_fire;
   logic                 req_beat;
   bundle_type           bundle;
   lexeme_type           rsp_token;

   assign scan_fire  = in_valid_ff && bundle_free;
   assign req_tready = !in_valid_ff || bundle_free;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (scan_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         char_ff <= req_tdata;
         eos_ff  <= req_tlast;
      end
   end

   stc_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .fire          (scan_fire),
      .char_code     (char_ff),
      .end_of_source (eos_ff),
      .bundle        (bundle)
   );

   stc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (scan_fire),
      .bundle    (bundle),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_token (rsp_token),
      .out_last  (rsp_tlast),
      .free      (bundle_free)
   );

   assign rsp_tuser = rsp_token.kind;
   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, rsp_token.column, rsp_token.line,
                       rsp_token.length, rsp_token.start};

`ifndef SYNTHESIS
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !bundle_free |=> in_valid_ff)
      else $error("Request beat lost while the result register was full.");

   a_end_token: assert property (@(posedge clock) disable iff (reset)
      scan_fire && eos_ff |=> rsp_tvalid)
      else $error("End of source gave no token.");
`endif

endmodule

>>> tb/sv/token_stream_checker.sv
`timescale 1ns / 1ps

module token_stream_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // char_code [7:0]
   input  logic [stc_pkg::CHAR_BITS-1:0]     req_tdata,
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // token_start [23:0], token_length [39:24], token_line [59:40],
   // token_column [75:60], zero fill above
   input  logic [stc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // token_kind [3:0]
   input  logic [stc_pkg::KIND_BITS-1:0]     rsp_tuser,
   input  logic                              rsp_tlast,
   output int                                failure_count,
   output int                                tokens_waiting,
   output int                                tokens_checked
);

   import stc_pkg::*;

   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [31:0] LENGTH_MAX = 32'd65535;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_IDENT,
      SCAN_INT,
      SCAN_DOT,
      SCAN_FRAC,
      SCAN_STRING
   } scan_mode_type;

   typedef struct packed {
      lexeme_type tok;
      logic       last;
   } expected_lexeme_type;

   expected_lexeme_type expected_tokens[$];

   scan_mode_type scan_mode;
   logic [31:0]   byte_offset;
   logic [31:0]   token_begin;
   logic [31:0]   line_count;
   logic [31:0]   column_count;
   logic [31:0]   begin_column;
   logic [31:0]   token_length;

   lexeme_type    beat_tokens [3];
   int            beat_count;
   int            mismatches = 0;
   int            checked = 0;

   function automatic logic [31:0] sat_inc(input logic [31:0] v, input int bits);
      logic [31:0] top;
      top = 32'((64'd1 << bits) - 64'd1);
      return (v >= top) ? top : v + 32'd1;
   endfunction

   function automatic logic ident_head(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic decimal_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task automatic push_token(input logic [KIND_BITS-1:0] kind, input logic [31:0] start,
                             input logic [31:0] len, input logic [31:0] col);
      lexeme_type t;
      t.kind   = kind;
      t.start  = start[START_BITS-1:0];
      t.length = len[LENGTH_BITS-1:0];
      t.line   = line_count[TLINE_BITS-1:0];
      t.column = col[TCOL_BITS-1:0];
      if (beat_count < 3) begin
         beat_tokens[beat_count] = t;
         beat_count++;
      end
   endtask

   task automatic push_pending(input logic [KIND_BITS-1:0] kind);
      push_token(kind, token_begin, token_length, begin_column);
   endtask

   task automatic push_dot_error();
      push_token(KIND_ERROR, byte_offset - 32'd1, 32'd1, column_count - 32'd1);
   endtask

   task automatic advance(input logic [7:0] c);
      byte_offset = sat_inc(byte_offset, OFFSET_BITS);
      if (c == CHAR_LF) begin
         line_count   = sat_inc(line_count, LINE_BITS);
         column_count = 32'd1;
      end else begin
         column_count = sat_inc(column_count, COLUMN_BITS);
      end
   endtask

   task automatic extend(input logic [7:0] c);
      if (token_length < LENGTH_MAX) token_length++;
      advance(c);
   endtask

   task automatic begin_token(input logic [7:0] c);
      scan_mode = SCAN_IDLE;
      if (c == " " || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) begin
         advance(c);
      end else begin
         token_begin  = byte_offset;
         begin_column = column_count;
         token_length = 32'd1;
         if (c == "+") push_pending(KIND_PLUS);
         else if (c == "-") push_pending(KIND_MINUS);
         else if (c == "=") push_pending(KIND_EQUALS);
         else if (c == ";") push_pending(KIND_SEMICOLON);
         else if (c == "(") push_pending(KIND_LPAREN);
         else if (c == ")") push_pending(KIND_RPAREN);
         else if (ident_head(c)) scan_mode = SCAN_IDENT;
         else if (decimal_digit(c)) scan_mode = SCAN_INT;
         else if (c == "\"") scan_mode = SCAN_STRING;
         else push_pending(KIND_ERROR);
         advance(c);
      end
   endtask

   task automatic scan_source_byte(input logic [7:0] c, input logic eos);
      expected_lexeme_type e;
      beat_count = 0;
      if (eos) begin
         case (scan_mode)
            SCAN_IDENT: push_pending(KIND_IDENT);
            SCAN_INT, SCAN_FRAC: push_pending(KIND_NUMBER);
            SCAN_DOT: begin
               push_pending(KIND_NUMBER);
               push_dot_error();
            end
            SCAN_STRING: push_pending(KIND_ERROR);
            default: ;
         endcase
         scan_mode = SCAN_IDLE;
         push_token(KIND_END, byte_offset, 32'd0, column_count);
      end else begin
         case (scan_mode)
            SCAN_IDENT: begin
               if (ident_head(c) || decimal_digit(c)) extend(c);
               else begin
                  push_pending(KIND_IDENT);
                  begin_token(c);
               end
            end
            SCAN_INT: begin
               if (decimal_digit(c)) extend(c);
               else if (c == ".") begin
                  scan_mode = SCAN_DOT;
                  advance(c);
               end else begin
                  push_pending(KIND_NUMBER);
                  begin_token(c);
               end
            end
            SCAN_DOT: begin
               if (decimal_digit(c)) begin
                  token_length = (token_length + 32'd2 > LENGTH_MAX) ? LENGTH_MAX
                                                                     : token_length + 32'd2;
                  scan_mode = SCAN_FRAC;
                  advance(c);
               end else begin
                  push_pending(KIND_NUMBER);
                  push_dot_error();
                  begin_token(c);
               end
            end
            SCAN_FRAC: begin
               if (decimal_digit(c)) extend(c);
               else begin
                  push_pending(KIND_NUMBER);
                  begin_token(c);
               end
            end
            SCAN_STRING: begin
               if (c == "\"") begin
                  if (token_length < LENGTH_MAX) token_length++;
                  push_pending(KIND_STRING);
                  scan_mode = SCAN_IDLE;
                  advance(c);
               end else if (c == CHAR_LF) begin
                  push_pending(KIND_ERROR);
                  begin_token(c);
               end else begin
                  extend(c);
               end
            end
            default: begin_token(c);
         endcase
      end
      for (int i = 0; i < beat_count; i++) begin
         e.tok  = beat_tokens[i];
         e.last = (i == beat_count - 1);
         expected_tokens.push_back(e);
      end
   endtask

   always @(posedge clock) begin
      lexeme_type          got;
      expected_lexeme_type want;
      if (reset) begin
         scan_mode    = SCAN_IDLE;
         byte_offset  = 32'd0;
         token_begin  = 32'd0;
         line_count   = 32'd1;
         column_count = 32'd1;
         begin_column = 32'd1;
         token_length = 32'd0;
         expected_tokens.delete();
      end else begin
         if (req_tvalid && req_tready) scan_source_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.kind   = rsp_tuser;
            got.start  = rsp_tdata[START_BITS-1:0];
            got.length = rsp_tdata[START_BITS +: LENGTH_BITS];
            got.line   = rsp_tdata[START_BITS + LENGTH_BITS +: TLINE_BITS];
            got.column = rsp_tdata[START_BITS + LENGTH_BITS + TLINE_BITS +: TCOL_BITS];
            if (expected_tokens.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected token kind %0d start %0d len %0d %s %0d col %0d",
                           $realtime, got.kind, got.start, got.length, "line",
                           got.line, got.column);
            end else begin
               want = expected_tokens.pop_front();
               if (got !== want.tok || rsp_tlast !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: token %0d expected kind %0d start %0d len %0d",
                              $realtime, checked, want.tok.kind, want.tok.start,
                              want.tok.length);
                     $display("   expected line %0d col %0d last %0b",
                              want.tok.line, want.tok.column, want.last);
                     $display("%0t: token %0d actual   kind %0d start %0d len %0d",
                              $realtime, checked, got.kind, got.start, got.length);
                     $display("   actual   line %0d col %0d last %0b",
                              got.line, got.column, rsp_tlast);
                  end
               end
            end
            checked++;
         end
      end
      failure_count  <= mismatches;
      tokens_waiting <= expected_tokens.size();
      tokens_checked <= checked;
   end

endmodule

>>> tb/sv/tb_source_char_tokenizer_top.sv
`timescale 1ns / 1ps

module tb_source_char_tokenizer_top;

   import stc_pkg::*;

   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam int RANDOM_BEATS = 184;
   localparam int LONG_HOLD    = 80;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [CHAR_BITS-1:0]     req_tdata = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [KIND_BITS-1:0]     rsp_tuser;
   logic                     rsp_tlast;

   int   failure_count;
   int   tokens_waiting;
   int   tokens_checked;

   int   beats_sent = 0;
   int   ends_sent = 0;
   int   burst_left = 0;
   logic no_gaps = 1'b0;
   logic hold_request = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left = 0;
   int   phase_left = 0;
   int   stall_pct = 0;
   int   directed_beats;
   int   hold_start;
   int   failures;

   always #5 clock = ~clock;

   source_char_tokenizer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   token_stream_checker token_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .failure_count  (failure_count),
      .tokens_waiting (tokens_waiting),
      .tokens_checked (tokens_checked)
   );

   // The receiver changes its stall rate from phase to phase and holds off
   // once for a long stretch so that the block backs up into its input.
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = LONG_HOLD;
      end
      if (phase_left == 0) begin
         phase_left = $urandom_range(20, 80);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
      end
      phase_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   task automatic send_beat(input logic [7:0] c, input logic eos);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = no_gaps ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      if (eos) ends_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   function automatic logic [7:0] pick_from(input string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   // Mostly well-formed tokens with random content, with some stray bytes
   // and the odd end of source falling in the middle of a token.
   task automatic send_random_token();
      int pick;
      int n;
      string alpha;
      string digits;
      string body;
      alpha  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
      digits = "0123456789";
      body   = "abcxyz XYZ_019+-=;()./*\t";
      pick   = $urandom_range(0, 99);
      if (pick < 20) begin
         send_beat(pick_from(alpha), 1'b0);
         n = $urandom_range(0, 5);
         repeat (n) send_beat(pick_from({alpha, digits}), 1'b0);
      end else if (pick < 38) begin
         n = $urandom_range(1, 4);
         repeat (n) send_beat(pick_from(digits), 1'b0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               send_beat(".", 1'b0);
               n = $urandom_range(1, 3);
               repeat (n) send_beat(pick_from(digits), 1'b0);
            end
            5, 6: send_beat(".", 1'b0);
            default: ;
         endcase
      end else if (pick < 50) begin
         send_beat("\"", 1'b0);
         n = $urandom_range(0, 6);
         repeat (n) send_beat(pick_from(body), 1'b0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: send_beat("\"", 1'b0);
            7, 8: send_beat(CHAR_LF, 1'b0);
            default: ;
         endcase
      end else if (pick < 70) begin
         send_beat(pick_from("+-=;()"), 1'b0);
      end else if (pick < 85) begin
         case ($urandom_range(0, 3))
            0: send_beat(" ", 1'b0);
            1: send_beat(CHAR_TAB, 1'b0);
            2: send_beat(CHAR_CR, 1'b0);
            default: send_beat(CHAR_LF, 1'b0);
         endcase
      end else if (pick < 96) begin
         send_beat(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_text("x9 12.5;");
      send_text("(\"s");
      send_beat(CHAR_LF, 1'b0);
      send_text("3.)");
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_text(".+-=");
      send_beat(CHAR_TAB, 1'b0);
      send_beat(CHAR_CR, 1'b0);
      send_text("7.");
      send_beat(8'hA5, 1'b1);
      directed_beats = beats_sent;

      hold_start = directed_beats + 90;
      while (beats_sent < directed_beats + RANDOM_BEATS) begin
         if (beats_sent >= hold_start && !hold_request) begin
            hold_request <= 1'b1;
            no_gaps = 1'b1;
         end
         if (beats_sent >= hold_start + 40) no_gaps = 1'b0;
         send_random_token();
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      req_tvalid <= 1'b0;

      do @(posedge clock); while (tokens_waiting != 0);
      repeat (20) @(posedge clock);

      failures = failure_count + tokens_waiting;
      if (tokens_waiting != 0) $display("%0d expected tokens never arrived", tokens_waiting);
      $display("Run covered %0d source beats, %0d of them end-of-source marks,", beats_sent,
               ends_sent);
      $display("and %0d tokens compared, with one long receiver hold-off.", tokens_checked);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d tokens outstanding", tokens_waiting);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
sv/stc_pkg.sv
sv/stc_scan.sv
sv/stc_emit.sv
sv/source_char_tokenizer_top.sv
tb/sv/token_stream_checker.sv
tb/sv/tb_source_char_tokenizer_top.sv
